// ----- rtl/aesctr_pkg.sv -----
package aesctr_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0]   data;
        logic         new_block;
        logic [3:0]   pos;
        logic [127:0] ctr;
    } entry_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TABLE[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                t[row + 4 * c] = sbox(s[127 - 8 * (row + 4 * ((c + row) % 4)) -: 8]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                x = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ x ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

endpackage

// ----- rtl/aes128_ctr_stream_cipher_unit.sv -----
// AES-128 counter-mode byte cipher; encryption and decryption are the same
// transaction. Load key (index 0 high, 1 low) and initial counter (index 2
// high, 3 low) while idle; raise message_start with the first byte of each
// message. Bytes within a block flow at one per cycle while the receiver
// keeps out_ready high. Each 16-byte block first waits for the iterative AES
// core (one round per cycle, key schedule computed alongside). A small queue
// lets input transactions keep arriving while the core runs.
module aes128_ctr_stream_cipher_unit #(
    parameter int QUEUE_DEPTH = aesctr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_in,
    input  logic        message_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_out
);
    import aesctr_pkg::*;

    localparam logic [1:0] REG_KEY_HIGH   = 2'd0;
    localparam logic [1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [1:0] REG_NONCE_HIGH = 2'd2;
    localparam logic [1:0] REG_NONCE_LOW  = 2'd3;

    logic [63:0] key_high_reg, key_low_reg, nonce_high_reg, nonce_low_reg;
    logic        q_full, q_push, q_pop, q_not_empty;
    entry_t      q_entry, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            nonce_high_reg <= '0;
            nonce_low_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    aesctr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_in       (data_in),
        .message_start (message_start),
        .nonce         ({nonce_high_reg, nonce_low_reg}),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    aesctr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    aesctr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out)
    );
endmodule

// ----- rtl/aesctr_front.sv -----
module aesctr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_in,
    input  logic                  message_start,
    input  logic [127:0]          nonce,
    input  logic                  q_full,
    output logic                  q_push,
    output aesctr_pkg::entry_t    q_entry
);
    import aesctr_pkg::*;

    logic [127:0] ctr_reg, ctr_next, ctr_cur;
    logic [3:0]   pos_reg, pos_next, pos_cur;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        ctr_cur = message_start ? nonce : ctr_reg;
        pos_cur = message_start ? 4'd0 : pos_reg;
        q_entry.data      = data_in;
        q_entry.new_block = (pos_cur == 4'd0);
        q_entry.pos       = pos_cur;
        q_entry.ctr       = ctr_cur;
        ctr_next = ctr_reg;
        pos_next = pos_reg;
        if (q_push)
        begin
            ctr_next = q_entry.new_block ? ctr_cur + 128'd1 : ctr_cur;
            pos_next = pos_cur + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
            pos_reg <= pos_next;
        end
    end
endmodule

// ----- rtl/aesctr_queue.sv -----
module aesctr_queue #(
    parameter int DEPTH = aesctr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aesctr_pkg::entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output aesctr_pkg::entry_t head
);
    import aesctr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end
endmodule

// ----- rtl/aesctr_back.sv -----
module aesctr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [127:0]       key,
    input  logic               not_empty,
    input  aesctr_pkg::entry_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         data_out
);
    import aesctr_pkg::*;

    typedef enum logic [1:0] {
        S_SERVE = 2'b01,
        S_RUN   = 2'b10
    } state_t;

    state_t       state_reg, state_next;
    logic [127:0] st_reg, st_next, rk_reg, rk_next, ks_reg, ks_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         fresh_reg, fresh_next;
    logic         valid_reg, valid_next;
    logic [7:0]   dout_reg, dout_next;
    logic [127:0] rk_step, st_step;

    assign out_valid = valid_reg;
    assign data_out  = dout_reg;

    always_comb
    begin
        rk_step    = key_expand(rk_reg, rcon(rnd_reg));
        st_step    = aes_round(st_reg, rk_step, rnd_reg == 4'd10);
        state_next = state_reg;
        st_next    = st_reg;
        rk_next    = rk_reg;
        ks_next    = ks_reg;
        rnd_next   = rnd_reg;
        fresh_next = fresh_reg;
        valid_next = valid_reg && !out_ready;
        dout_next  = dout_reg;
        pop        = 1'b0;
        case (state_reg)
            S_SERVE:
            begin
                if (not_empty && head.new_block && !fresh_reg)
                begin
                    st_next    = head.ctr ^ key;
                    rk_next    = key;
                    rnd_next   = 4'd1;
                    state_next = S_RUN;
                end
                else if (not_empty && (!valid_reg || out_ready))
                begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    dout_next  = head.data ^ ks_reg[{~head.pos, 3'b000} +: 8];
                    if (head.new_block)
                    begin
                        fresh_next = 1'b0;
                    end
                end
            end
            S_RUN:
            begin
                st_next  = st_step;
                rk_next  = rk_step;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd10)
                begin
                    ks_next    = st_step;
                    fresh_next = 1'b1;
                    state_next = S_SERVE;
                end
            end
            default:
            begin
                state_next = S_SERVE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        rk_reg   <= rk_next;
        ks_reg   <= ks_next;
        dout_reg <= dout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SERVE;
            rnd_reg   <= '0;
            fresh_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fresh_reg <= fresh_next;
            valid_reg <= valid_next;
        end
    end
endmodule

// ----- tb/sv/aes128_ctr_stream_cipher_unit_tb.sv -----
`timescale 1ns / 1ps

module aes128_ctr_stream_cipher_unit_tb;

    localparam logic [1:0] REG_KEY_HIGH   = 2'd0;
    localparam logic [1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [1:0] REG_NONCE_HIGH = 2'd2;
    localparam logic [1:0] REG_NONCE_LOW  = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_in = '0;
    logic        message_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_out;

    logic [7:0] sub_tab [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [127:0] cipher_key;
    logic [127:0] nonce_block;
    logic [127:0] counter_block;
    logic [7:0]   keystream [16];
    logic [3:0]   block_pos;

    logic [7:0] expected_bytes [$];
    int fails;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int quiet_cycles;

    aes128_ctr_stream_cipher_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_in       (data_in),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_out      (data_out)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] gf_twice(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_block(input logic [127:0] key, input logic [127:0] pt);
        logic [31:0] w [44];
        logic [31:0] tw;
        logic [7:0]  rc;
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  a0, a1, a2, a3, x;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            w[i] = key[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            tw = w[i - 1];
            if (i % 4 == 0)
            begin
                tw = {sub_tab[tw[23:16]] ^ rc, sub_tab[tw[15:8]], sub_tab[tw[7:0]],
                      sub_tab[tw[31:24]]};
                rc = gf_twice(rc);
            end
            w[i] = w[i - 4] ^ tw;
        end
        for (int i = 0; i < 16; i++)
            s[i] = pt[127 - 8 * i -: 8] ^ w[i / 4][31 - 8 * (i % 4) -: 8];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[row + 4 * c] = sub_tab[s[row + 4 * ((c + row) % 4)]];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c];
                    a1 = t[4 * c + 1];
                    a2 = t[4 * c + 2];
                    a3 = t[4 * c + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[4 * c]     = a0 ^ x ^ gf_twice(a0 ^ a1);
                    t[4 * c + 1] = a1 ^ x ^ gf_twice(a1 ^ a2);
                    t[4 * c + 2] = a2 ^ x ^ gf_twice(a2 ^ a3);
                    t[4 * c + 3] = a3 ^ x ^ gf_twice(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ w[4 * r + i / 4][31 - 8 * (i % 4) -: 8];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    function automatic logic [7:0] ctr_crypt(input logic [7:0] din, input logic start);
        logic [127:0] blk;
        logic [7:0] res;
        if (start)
        begin
            counter_block = nonce_block;
            block_pos = '0;
        end
        if (block_pos == 0)
        begin
            blk = aes_block(cipher_key, counter_block);
            for (int i = 0; i < 16; i++)
                keystream[i] = blk[127 - 8 * i -: 8];
            counter_block = counter_block + 128'd1;
        end
        res = din ^ keystream[block_pos];
        block_pos = block_pos + 4'd1;
        return res;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_KEY_HIGH:   cipher_key[127:64] = value;
            REG_KEY_LOW:    cipher_key[63:0] = value;
            REG_NONCE_HIGH: nonce_block[127:64] = value;
            REG_NONCE_LOW:  nonce_block[63:0] = value;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [127:0] key, input logic [127:0] nonce);
        write_reg(REG_KEY_HIGH, key[127:64]);
        write_reg(REG_KEY_LOW, key[63:0]);
        write_reg(REG_NONCE_HIGH, nonce[127:64]);
        write_reg(REG_NONCE_LOW, nonce[63:0]);
    endtask

    task automatic send_byte(input logic [7:0] din, input logic start);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_in <= din;
        message_start <= start;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        expected_bytes.push_back(ctr_crypt(din, start));
    endtask

    task automatic send_message(input int len, input logic with_start);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), with_start && i == 0);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("data_out: no transaction expected, actual %02h", data_out);
                fails++;
            end
            else
            begin
                if (data_out !== expected_bytes[0])
                begin
                    $error("data_out: expected %02h actual %02h", expected_bytes[0], data_out);
                    fails++;
                end
                void'(expected_bytes.pop_front());
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (expected_bytes.size() == 0 && !in_valid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("aes128_ctr_stream_cipher_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic test_reset_stream;
        for (int i = 0; i < 20; i++)
            send_byte(i[0] ? 8'hff : 8'h00, 1'b0);
        drain();
    endtask

    task automatic test_extremes_and_restart;
        write_all({64'h2b7e151628aed2a6, 64'habf7158809cf4f3c},
                  {64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff});
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        send_message(18, 1'b0);
        drain();
    endtask

    task automatic test_key_change_mid_block;
        send_message(7, 1'b1);
        drain();
        write_reg(REG_KEY_HIGH, 64'hffffffffffffffff);
        write_reg(REG_KEY_LOW, 64'h0);
        send_message(20, 1'b0);
        drain();
    endtask

    task automatic test_nonce_change_mid_message;
        send_message(5, 1'b1);
        drain();
        write_reg(REG_NONCE_HIGH, 64'h0123456789abcdef);
        write_reg(REG_NONCE_LOW, 64'hfedcba9876543210);
        send_message(14, 1'b0);
        send_message(6, 1'b1);
        drain();
    endtask

    task automatic test_counter_wrap;
        write_all({128{1'b1}}, {128{1'b1}});
        send_message(40, 1'b1);
        drain();
        write_all('0, {64'h0, 64'hffffffffffffffff});
        send_message(36, 1'b1);
        drain();
    endtask

    task automatic test_backpressure;
        hold_left = 300;
        send_message(40, 1'b1);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        int sent;
        int len;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                drain();
                write_all({$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom, $urandom, $urandom});
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(80, 1) : $urandom_range(34, 1);
            send_message(len, $urandom_range(9) != 0);
            sent += len;
        end
        drain();
    endtask

    initial
    begin
        fails = 0;
        hold_left = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cipher_key = '0;
        nonce_block = '0;
        counter_block = '0;
        block_pos = '0;
        for (int i = 0; i < 16; i++)
            keystream[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_stream();
        test_extremes_and_restart();
        test_key_change_mid_block();
        test_nonce_change_mid_message();
        test_counter_wrap();
        test_backpressure();
        test_random_traffic(0, 0, 360);
        test_random_traffic(61, 0, 360);
        test_random_traffic(0, 61, 360);
        test_random_traffic(6, 6, 360);

        if (fails == 0)
            $display("aes128_ctr_stream_cipher_unit_tb OK");
        else
            $display("aes128_ctr_stream_cipher_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/aesctr_pkg.sv
rtl/aesctr_front.sv
rtl/aesctr_queue.sv
rtl/aesctr_back.sv
rtl/aes128_ctr_stream_cipher_unit.sv
tb/sv/aes128_ctr_stream_cipher_unit_tb.sv
